>>> hdl/bgc_pkg.sv
// Shared types and constants of the button gesture classifier.
package bgc_pkg;

  localparam int unsigned CFG_W  = 16;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SINGLE = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_e;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [1:0] REG_MIN_PRESS  = 2'd1;
  localparam logic [1:0] REG_DOUBLE_GAP = 2'd2;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd3000;
  localparam logic [CFG_W-1:0] MIN_PRESS_RST  = 16'd50;
  localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = 16'd500;

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] min_press_ms;
    logic [CFG_W-1:0] double_gap_ms;
  } cfg_t;

endpackage

>>> hdl/bgc_core.sv
// Gesture state registers and the per-tick classification logic.
module bgc_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               down_i,
  input  bgc_pkg::cfg_t      cfg_i,
  output bgc_pkg::gesture_e  gesture_o,
  output logic               mute_o
);

  localparam int unsigned CW = (TIMER_BITS > bgc_pkg::CFG_W) ? TIMER_BITS : bgc_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic                  held_q, held_d;
  logic [TIMER_BITS-1:0] hold_q, hold_d;
  logic [TIMER_BITS-1:0] since_q, since_d;
  logic [1:0]            cnt_q, cnt_d;
  logic                  mute_q, mute_d;

  logic [TIMER_BITS-1:0] gap;
  logic [TIMER_BITS-1:0] dur;
  logic [CW-1:0]         dur_x, long_x, min_x, dbl_x, gap_x;

  assign gap    = (since_q == TMAX) ? since_q : since_q + 1'b1;
  assign dur    = (hold_q == TMAX) ? hold_q : hold_q + 1'b1;
  assign dur_x  = CW'(dur);
  assign gap_x  = CW'(gap);
  assign long_x = CW'(cfg_i.long_press_ms);
  assign min_x  = CW'(cfg_i.min_press_ms);
  assign dbl_x  = CW'(cfg_i.double_gap_ms);

  always_comb begin
    logic [TIMER_BITS-1:0] gap_v;
    logic [1:0]            cnt_v;
    bgc_pkg::gesture_e     gest_v;
    held_d = held_q;
    hold_d = hold_q;
    cnt_v  = cnt_q;
    mute_d = mute_q;
    gap_v  = gap;
    gest_v = bgc_pkg::GEST_NONE;
    if (down_i && !held_q) begin
      held_d = 1'b1;
      hold_d = '0;
    end else if (down_i && held_q) begin
      hold_d = dur;
    end else if (!down_i && held_q) begin
      held_d = 1'b0;
      if (dur_x >= long_x) begin
        gest_v = bgc_pkg::GEST_LONG;
      end else if (dur_x >= min_x) begin
        if (gap_x < dbl_x) begin
          cnt_v = (cnt_q == 2'd3) ? 2'd3 : cnt_q + 2'd1;
        end else begin
          cnt_v = 2'd1;
        end
        gap_v = '0;
        if (cnt_v >= 2'd2) begin
          mute_d = ~mute_q;
          cnt_v  = 2'd0;
          gest_v = bgc_pkg::GEST_DOUBLE;
        end
      end
    end
    // A pending short press that has outlived the window is a single press,
    // unless this tick already reports something.
    if (gest_v == bgc_pkg::GEST_NONE && cnt_v == 2'd1 && CW'(gap_v) > dbl_x) begin
      gest_v = bgc_pkg::GEST_SINGLE;
      cnt_v  = 2'd0;
    end
    since_d   = gap_v;
    cnt_d     = cnt_v;
    gesture_o = gest_v;
  end

  assign mute_o = mute_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      hold_q  <= '0;
      since_q <= TMAX;
      cnt_q   <= 2'd0;
      mute_q  <= 1'b0;
    end else if (step_i) begin
      held_q  <= held_d;
      hold_q  <= hold_d;
      since_q <= since_d;
      cnt_q   <= cnt_d;
      mute_q  <= mute_d;
    end
  end

endmodule

>>> hdl/button_gesture_classifier_top.sv
// Top level of the button gesture classifier: register port, tick pipeline and result register.
// Each input beat is one millisecond tick carrying the button level and yields exactly one
// result beat with the gesture seen at that tick and the mute flag after it. A tick is held in the
// input register and then moves into the result register, where its result is presented; a new
// tick is taken every cycle as long as the result register is empty or being drained. The user
// must write thresholds through the register port only while no tick is in flight; the block
// itself does not enforce this.
module button_gesture_classifier_top #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        button_down_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  gesture_o,
  output logic                        mute_on_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bgc_pkg::ADDR_W-1:0]  paddr,
  input  logic [bgc_pkg::DATA_W-1:0]  pwdata,
  output logic [bgc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  bgc_pkg::cfg_t     cfg_q;
  logic [1:0]        reg_idx;
  logic              wr_en;

  logic              in_v_q;
  logic              down_q;
  logic              out_v_q;
  bgc_pkg::gesture_e gest_q;
  logic              mute_q;

  logic              adv;
  logic              step;
  bgc_pkg::gesture_e gest_c;
  logic              mute_c;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ms <= bgc_pkg::LONG_PRESS_RST;
      cfg_q.min_press_ms  <= bgc_pkg::MIN_PRESS_RST;
      cfg_q.double_gap_ms <= bgc_pkg::DOUBLE_GAP_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        bgc_pkg::REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[bgc_pkg::CFG_W-1:0];
        bgc_pkg::REG_MIN_PRESS:  cfg_q.min_press_ms  <= pwdata[bgc_pkg::CFG_W-1:0];
        bgc_pkg::REG_DOUBLE_GAP: cfg_q.double_gap_ms <= pwdata[bgc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bgc_pkg::REG_LONG_PRESS: prdata = bgc_pkg::DATA_W'(cfg_q.long_press_ms);
      bgc_pkg::REG_MIN_PRESS:  prdata = bgc_pkg::DATA_W'(cfg_q.min_press_ms);
      bgc_pkg::REG_DOUBLE_GAP: prdata = bgc_pkg::DATA_W'(cfg_q.double_gap_ms);
      default:                 prdata = '0;
    endcase
  end

  // The state is updated only when the registered tick moves into the result register.
  assign adv        = !out_v_q || out_ready_i;
  assign step       = in_v_q && adv;
  assign in_ready_o = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (adv) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      down_q <= button_down_i;
    end
    if (step) begin
      gest_q <= gest_c;
      mute_q <= mute_c;
    end
  end

  bgc_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .down_i    (down_q),
    .cfg_i     (cfg_q),
    .gesture_o (gest_c),
    .mute_o    (mute_c)
  );

  assign out_valid_o = out_v_q;
  assign gesture_o   = gest_q;
  assign mute_on_o   = mute_q;

endmodule

>>> hdl/bgc_checker.sv
// Port-level checks of the button gesture classifier and their binding to the top level.
module bgc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] gesture_o,
  input logic       mute_on_o
);

  logic       last_mute_q;
  logic [1:0] last_gest_q;

  // Mute flag and gesture of the previous result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_mute_q <= 1'b0;
      last_gest_q <= bgc_pkg::GEST_NONE;
    end else if (out_valid_o && out_ready_i) begin
      last_mute_q <= mute_on_o;
      last_gest_q <= gesture_o;
    end
  end

  a_double_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gesture_o == bgc_pkg::GEST_DOUBLE |-> mute_on_o != last_mute_q)
    else $error("double press beat did not toggle mute");

  a_mute_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gesture_o != bgc_pkg::GEST_DOUBLE |-> mute_on_o == last_mute_q)
    else $error("mute changed without a double press");

  a_double_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gesture_o == bgc_pkg::GEST_DOUBLE |->
      last_gest_q != bgc_pkg::GEST_SINGLE && last_gest_q != bgc_pkg::GEST_DOUBLE)
    else $error("double press directly after a single or double press");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while the result register is empty");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(gesture_o) && $stable(mute_on_o))
    else $error("stalled result beat changed");

endmodule

bind button_gesture_classifier_top bgc_checker u_bgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .gesture_o   (gesture_o),
  .mute_on_o   (mute_on_o)
);

>>> test/tb_button_gesture_classifier_top.sv
// Self-checking testbench for the button gesture classifier: directed table, then random presses.
module tb_button_gesture_classifier_top;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam logic [15:0] TIMER_MAX   = 16'hFFFF;

  typedef enum logic {ROW_TICKS, ROW_CFG} row_kind_e;

  typedef struct packed {
    bgc_pkg::gesture_e gest;
    logic              mute;
  } tick_result_t;

  // A ticks row repeats one button level; its typed result, if any, is that of its last tick.
  typedef struct packed {
    row_kind_e         kind;
    logic              down;
    logic [7:0]        reps;
    logic              typed;
    bgc_pkg::gesture_e gest;
    logic              mute;
    logic [15:0]       long_ms;
    logic [15:0]       min_ms;
    logic [15:0]       gap_ms;
  } stim_row_t;

  localparam int unsigned N_ROWS = 20;

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_TICKS, 1'b0, 8'd1, 1'b1, bgc_pkg::GEST_NONE,   1'b0, '0, '0, '0},
    '{ROW_CFG,   1'b0, 8'd0, 1'b0, bgc_pkg::GEST_NONE,   1'b0, 16'd6, 16'd2, 16'd4},
    '{ROW_TICKS, 1'b1, 8'd1, 1'b0, bgc_pkg::GEST_NONE,   1'b0, '0, '0, '0},
    '{ROW_TICKS, 1'b0, 8'd1, 1'b1, bgc_pkg::GEST_NONE,   1'b0, '0, '0, '0},
    '{ROW_TICKS, 1'b1, 8'd2, 1'b0, bgc_pkg::GEST_NONE,   1'b0, '0, '0, '0},
    '{ROW_TICKS, 1'b0, 8'd1, 1'b1, bgc_pkg::GEST_NONE,   1'b0, '0, '0, '0},
    '{ROW_TICKS, 1'b1, 8'd2, 1'b0, bgc_pkg::GEST_NONE,   1'b0, '0, '0, '0},
    '{ROW_TICKS, 1'b0, 8'd1, 1'b1, bgc_pkg::GEST_DOUBLE, 1'b1, '0, '0, '0},
    '{ROW_TICKS, 1'b1, 8'd6, 1'b0, bgc_pkg::GEST_NONE,   1'b0, '0, '0, '0},
    '{ROW_TICKS, 1'b0, 8'd1, 1'b1, bgc_pkg::GEST_LONG,   1'b1, '0, '0, '0},
    '{ROW_TICKS, 1'b1, 8'd2, 1'b0, bgc_pkg::GEST_NONE,   1'b0, '0, '0, '0},
    '{ROW_TICKS, 1'b0, 8'd1, 1'b1, bgc_pkg::GEST_NONE,   1'b1, '0, '0, '0},
    '{ROW_TICKS, 1'b0, 8'd4, 1'b1, bgc_pkg::GEST_NONE,   1'b1, '0, '0, '0},
    '{ROW_TICKS, 1'b0, 8'd1, 1'b1, bgc_pkg::GEST_SINGLE, 1'b1, '0, '0, '0},
    '{ROW_CFG,   1'b0, 8'd0, 1'b0, bgc_pkg::GEST_NONE,   1'b0, 16'd3, 16'd2, 16'd3},
    '{ROW_TICKS, 1'b1, 8'd2, 1'b0, bgc_pkg::GEST_NONE,   1'b0, '0, '0, '0},
    '{ROW_TICKS, 1'b0, 8'd1, 1'b1, bgc_pkg::GEST_NONE,   1'b1, '0, '0, '0},
    '{ROW_TICKS, 1'b1, 8'd3, 1'b0, bgc_pkg::GEST_NONE,   1'b0, '0, '0, '0},
    // Long press and single timeout fall on the same tick: the single follows one tick later.
    '{ROW_TICKS, 1'b0, 8'd1, 1'b1, bgc_pkg::GEST_LONG,   1'b1, '0, '0, '0},
    '{ROW_TICKS, 1'b0, 8'd1, 1'b1, bgc_pkg::GEST_SINGLE, 1'b1, '0, '0, '0}
  };

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic                         button_down_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [1:0]                   gesture_o;
  logic                         mute_on_o;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [bgc_pkg::ADDR_W-1:0]   paddr;
  logic [bgc_pkg::DATA_W-1:0]   pwdata;
  logic [bgc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  // Predicted state of the classifier and its thresholds.
  logic        held_q          = 1'b0;
  logic [15:0] hold_ms_q       = '0;
  logic [15:0] since_short_q   = TIMER_MAX;
  logic [1:0]  shorts_q        = '0;
  logic        mute_q          = 1'b0;
  logic [15:0] long_ms_q       = bgc_pkg::LONG_PRESS_RST;
  logic [15:0] min_ms_q        = bgc_pkg::MIN_PRESS_RST;
  logic [15:0] gap_win_q       = bgc_pkg::DOUBLE_GAP_RST;

  tick_result_t expected_events [$];
  int unsigned  mismatches = 0;
  bit           calm = 1'b0;
  int unsigned  stall_left = 0;

  button_gesture_classifier_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .button_down_i (button_down_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .gesture_o     (gesture_o),
    .mute_on_o     (mute_on_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  task automatic report(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == TIMER_MAX) ? TIMER_MAX : v + 16'd1;
  endfunction

  function automatic tick_result_t classify_tick(input logic down);
    logic [15:0]  gap_ms;
    logic [15:0]  dur_ms;
    tick_result_t res;
    res.gest = bgc_pkg::GEST_NONE;
    gap_ms = sat_inc(since_short_q);
    if (down && !held_q) begin
      held_q = 1'b1;
      hold_ms_q = '0;
    end else if (down && held_q) begin
      hold_ms_q = sat_inc(hold_ms_q);
    end else if (!down && held_q) begin
      dur_ms = sat_inc(hold_ms_q);
      held_q = 1'b0;
      if (dur_ms >= long_ms_q) begin
        res.gest = bgc_pkg::GEST_LONG;
      end else if (dur_ms >= min_ms_q) begin
        if (gap_ms < gap_win_q) begin
          shorts_q = (shorts_q == 2'd3) ? 2'd3 : shorts_q + 2'd1;
        end else begin
          shorts_q = 2'd1;
        end
        gap_ms = '0;
        if (shorts_q >= 2'd2) begin
          mute_q = ~mute_q;
          shorts_q = '0;
          res.gest = bgc_pkg::GEST_DOUBLE;
        end
      end
    end
    since_short_q = gap_ms;
    // A pending single press waits while a long press is being reported.
    if (res.gest == bgc_pkg::GEST_NONE && shorts_q == 2'd1 && gap_ms > gap_win_q) begin
      res.gest = bgc_pkg::GEST_SINGLE;
      shorts_q = '0;
    end
    res.mute = mute_q;
    return res;
  endfunction

  function automatic int unsigned pick_pause();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned near_edge(input logic [15:0] edge_ms);
    int v;
    v = int'(edge_ms) + int'($urandom_range(0, 2)) - 1;
    return (v < 0) ? 0 : v;
  endfunction

  task automatic send_tick(input logic down, input bit typed, input tick_result_t typed_res);
    int unsigned  pause;
    tick_result_t predicted;
    pause = pick_pause();
    if (pause != 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    button_down_i <= down;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = classify_tick(down);
    expected_events.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  task automatic hold_level(input logic down, input int unsigned n);
    repeat (n) send_tick(down, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] readback;
    apb_access(1'b1, idx, data, readback);
    case (idx)
      bgc_pkg::REG_LONG_PRESS: long_ms_q = data[15:0];
      bgc_pkg::REG_MIN_PRESS:  min_ms_q  = data[15:0];
      bgc_pkg::REG_DOUBLE_GAP: gap_win_q = data[15:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      apb_access(1'b0, idx, '0, readback);
      if (readback !== {16'h0000, data[15:0]}) begin
        report($sformatf("register %0d reads %h, wrote %h", idx, readback, data[15:0]));
      end
    end
  endtask

  // The upper half of each write is noise that the register must drop.
  task automatic set_thresholds(input logic [15:0] long_ms, input logic [15:0] min_ms,
                                input logic [15:0] gap_ms);
    wait_drained();
    write_reg(bgc_pkg::REG_LONG_PRESS, {16'($urandom), long_ms});
    write_reg(bgc_pkg::REG_MIN_PRESS,  {16'($urandom), min_ms});
    write_reg(bgc_pkg::REG_DOUBLE_GAP, {16'($urandom), gap_ms});
  endtask

  function automatic int unsigned pick_press();
    int unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = near_edge(min_ms_q);
      4, 5:       v = near_edge(long_ms_q);
      default:    v = $urandom_range(1, 12);
    endcase
    if (v == 0 || v > 4000) begin
      v = $urandom_range(1, 12);
    end
    return v;
  endfunction

  function automatic int unsigned pick_release_gap();
    int unsigned v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = near_edge(gap_win_q);
      4, 5, 6:    v = $urandom_range(0, 4);
      default:    v = $urandom_range(0, 20);
    endcase
    if (v > 4000) begin
      v = $urandom_range(0, 20);
    end
    return v;
  endfunction

  // Mostly whole presses sized around the thresholds, with bursts of random levels between.
  task automatic press_sequences(input int unsigned budget);
    int unsigned sent;
    int unsigned dur;
    int unsigned idle;
    int unsigned n;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) send_tick(1'($urandom_range(0, 1)), 1'b0, '0);
        sent += n;
      end else begin
        dur  = pick_press();
        idle = pick_release_gap();
        hold_level(1'b1, dur);
        hold_level(1'b0, idle + 1);
        sent += dur + idle + 1;
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] long_ms, input logic [15:0] min_ms,
                           input logic [15:0] gap_ms, input int unsigned budget);
    set_thresholds(long_ms, min_ms, gap_ms);
    calm = ($urandom_range(0, 3) == 0);
    press_sequences(budget);
  endtask

  // Output side: random back-pressure, mostly short stalls.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_pause();
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    tick_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        report($sformatf("result beat with nothing expected, gesture %0d", gesture_o));
      end else begin
        want = expected_events.pop_front();
        if (gesture_o !== want.gest) begin
          report($sformatf("gesture %0d, expected %0d", gesture_o, want.gest));
        end
        if (mute_on_o !== want.mute) begin
          report($sformatf("mute %0b, expected %0b", mute_on_o, want.mute));
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[button_gesture_classifier_top] ERROR");
    $finish;
  end

  initial begin
    tick_result_t typed_res;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    button_down_i = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        set_thresholds(directed_rows[i].long_ms, directed_rows[i].min_ms,
                       directed_rows[i].gap_ms);
      end else begin
        typed_res.gest = directed_rows[i].gest;
        typed_res.mute = directed_rows[i].mute;
        for (int k = 0; k < int'(directed_rows[i].reps); k++) begin
          send_tick(directed_rows[i].down,
                    directed_rows[i].typed && (k == int'(directed_rows[i].reps) - 1),
                    typed_res);
        end
      end
    end

    set_thresholds(16'd10, 16'd3, 16'd8);
    // A write beyond the last register must leave every threshold alone.
    write_reg(REG_UNUSED, $urandom);
    calm = 1'b0;
    press_sequences(150);

    run_phase(16'd0, 16'd0, 16'd0, 60);
    // With no pairing window every short press becomes a single on the next tick.
    run_phase(16'd20, 16'd0, 16'd0, 80);
    run_phase(16'd4, 16'd2, 16'd3, 150);

    // With the window at the saturated gap value a lone short press never times out.
    run_phase(16'hFFFF, 16'd2, 16'hFFFF, 60);
    hold_level(1'b1, 2);
    hold_level(1'b0, 1);
    press_sequences(60);

    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 40);
    run_phase(bgc_pkg::LONG_PRESS_RST, bgc_pkg::MIN_PRESS_RST, bgc_pkg::DOUBLE_GAP_RST, 250);

    wait_drained();
    if (mismatches == 0) begin
      $display("[button_gesture_classifier_top] OK");
    end else begin
      $display("[button_gesture_classifier_top] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/bgc_pkg.sv
hdl/bgc_core.sv
hdl/button_gesture_classifier_top.sv
hdl/bgc_checker.sv
test/tb_button_gesture_classifier_top.sv
